@@ design/assert_macros.svh @@
// Assertion helpers included by gap_pad_map_engine.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another one on the next rising clk edge.
`define ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ design/gpm_pkg.sv @@
package gpm_pkg;

	// default number of table entries
	localparam int TABLE_DEPTH_DEF = 1024;

	// pad marker in the gapped sequence
	localparam logic [7:0] PAD_CHAR = 8'h2A;

	// item selector
	typedef enum logic [1:0] {
		FUNC_PUSH  = 2'd0,
		FUNC_COORD = 2'd1,
		FUNC_COUNT = 2'd2,
		FUNC_CLEAR = 2'd3
	} func_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROBE,
		ST_SPLIT,
		ST_APPLY,
		ST_SH_RD,
		ST_SH_WR,
		ST_DONE
	} state_t;

	// one table entry as stored in memory
	typedef struct packed {
		logic [31:0] num_pads;
		logic [31:0] padded_pos;
		logic [31:0] pos;
	} entry_t;

	// one result word
	typedef struct packed {
		logic        table_full;
		logic [31:0] answer;
		logic        char_kept;
		logic [7:0]  char_out;
	} res_t;

endpackage

@@ design/gpm_table.sv @@
module gpm_table #(
	parameter int TABLE_DEPTH = gpm_pkg::TABLE_DEPTH_DEF,
	localparam int AW = $clog2(TABLE_DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  gpm_pkg::entry_t   wdata,
	input  logic [AW-1:0]     raddr,
	output gpm_pkg::entry_t   rdata
);
	import gpm_pkg::*;

	entry_t mem [TABLE_DEPTH];
	entry_t rdata_q;

	// write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/gpm_ctrl.sv @@
module gpm_ctrl #(
	parameter int TABLE_DEPTH = gpm_pkg::TABLE_DEPTH_DEF,
	localparam int AW = $clog2(TABLE_DEPTH),
	localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  gpm_pkg::func_t    in_func,
	input  logic [7:0]        in_char,
	input  logic [31:0]       in_coord,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_wdata,
	output logic              res_valid,
	input  logic              res_ready,
	output gpm_pkg::res_t     res,
	output logic              mem_we,
	output logic [AW-1:0]     mem_waddr,
	output gpm_pkg::entry_t   mem_wdata,
	output logic [AW-1:0]     mem_raddr,
	input  gpm_pkg::entry_t   mem_rdata
);
	import gpm_pkg::*;

	state_t      state_q, state_d;
	logic [CW-1:0] used_q;
	logic [31:0] counter_q;
	logic [31:0] total_q;
	logic [31:0] offset_q;

	// per-item working registers
	func_t       func_q;
	logic [31:0] key_q;
	logic [CW-1:0] lo_q;
	logic [CW-1:0] hi_q;
	logic [CW-1:0] idx_q;
	res_t        res_q;

	logic          accept;
	logic [CW-1:0] mid;
	logic [CW-1:0] lo_m1;
	logic [CW-1:0] idx_m1;
	logic          have;
	logic          hit;
	logic          key_lt;
	logic          full;
	logic          is_pad;

	assign accept = in_valid && in_ready;
	assign is_pad = (in_char == PAD_CHAR);
	assign mid    = lo_q + ((hi_q - lo_q) >> 1);
	assign lo_m1  = lo_q - CW'(1);
	assign idx_m1 = idx_q - CW'(1);
	assign have   = (lo_q != '0);
	assign hit    = have && (mem_rdata.pos == key_q);
	assign key_lt = $signed(key_q) < $signed(mem_rdata.pos);
	assign full   = (used_q >= CW'(TABLE_DEPTH));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_func == FUNC_CLEAR || (in_func == FUNC_PUSH && !is_pad)) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_PROBE;
					end
				end
			end
			ST_PROBE: begin
				state_d = (lo_q < hi_q) ? ST_SPLIT : ST_APPLY;
			end
			ST_SPLIT: begin
				state_d = ST_PROBE;
			end
			ST_APPLY: begin
				if (func_q == FUNC_PUSH && !hit && !full) begin
					state_d = ST_SH_RD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SH_RD: begin
				state_d = (idx_q > lo_q) ? ST_SH_WR : ST_DONE;
			end
			ST_SH_WR: begin
				state_d = ST_SH_RD;
			end
			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// memory ports and handshake
	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = lo_m1[AW-1:0];
		mem_wdata = mem_rdata;
		mem_raddr = mid[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_PROBE: begin
				// finished search: fetch the predecessor entry
				if (!(lo_q < hi_q)) begin
					mem_raddr = lo_m1[AW-1:0];
				end
			end
			ST_APPLY: begin
				// extend an existing entry in place
				if (func_q == FUNC_PUSH && hit) begin
					mem_we               = 1'b1;
					mem_waddr            = lo_m1[AW-1:0];
					mem_wdata.pos        = mem_rdata.pos;
					mem_wdata.padded_pos = mem_rdata.padded_pos + 32'd1;
					mem_wdata.num_pads   = mem_rdata.num_pads + 32'd1;
				end
			end
			ST_SH_RD: begin
				mem_raddr = idx_m1[AW-1:0];
				// shift done: drop the new entry into its slot
				if (!(idx_q > lo_q)) begin
					mem_we               = 1'b1;
					mem_waddr            = lo_q[AW-1:0];
					mem_wdata.pos        = key_q;
					mem_wdata.padded_pos = key_q + total_q;
					mem_wdata.num_pads   = 32'd1;
				end
			end
			ST_SH_WR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q[AW-1:0];
				mem_wdata = mem_rdata;
			end
			ST_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			used_q    <= '0;
			counter_q <= '0;
			total_q   <= '0;
			offset_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				offset_q <= cfg_wdata;
			end
			if (state_q == ST_IDLE && accept) begin
				if (in_func == FUNC_CLEAR) begin
					used_q    <= '0;
					counter_q <= '0;
					total_q   <= '0;
				end else if (in_func == FUNC_PUSH && !is_pad) begin
					counter_q <= counter_q + 32'd1;
				end
			end
			// count the pad unless it is dropped
			if (state_q == ST_APPLY && func_q == FUNC_PUSH && (hit || !full)) begin
				total_q <= total_q + 32'd1;
			end
			if (state_q == ST_SH_RD && !(idx_q > lo_q)) begin
				used_q <= used_q + CW'(1);
			end
		end
	end

	// per-item datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				func_q           <= in_func;
				key_q            <= (in_func == FUNC_PUSH) ? counter_q + offset_q : in_coord;
				lo_q             <= '0;
				hi_q             <= used_q;
				res_q.table_full <= 1'b0;
				res_q.answer     <= '0;
				res_q.char_kept  <= (in_func == FUNC_PUSH && !is_pad);
				res_q.char_out   <= (in_func == FUNC_PUSH && !is_pad) ? in_char : 8'h00;
			end
			ST_SPLIT: begin
				if (key_lt) begin
					hi_q <= mid;
				end else begin
					lo_q <= mid + CW'(1);
				end
			end
			ST_APPLY: begin
				idx_q <= used_q;
				unique case (func_q)
					FUNC_COORD: begin
						res_q.answer <= have
							? mem_rdata.padded_pos + key_q - mem_rdata.pos : key_q;
					end
					FUNC_COUNT: begin
						res_q.answer <= hit ? mem_rdata.num_pads : 32'd0;
					end
					FUNC_PUSH: begin
						res_q.table_full <= !hit && full;
					end
					default: begin
					end
				endcase
			end
			ST_SH_WR: begin
				idx_q <= idx_m1;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ design/gap_pad_map_engine.sv @@
// A kept character or a clear goes straight to the done state, and its result word is then
// registered in the output word register. Queries and pads binary-search the used entries in
// probe and split states, then apply. A new pad shifts later entries up by read and write
// states, then is put in. One item is in work at a time; table read/modify/write sets the rate.
// Reset clears the entry count, counters, offset and valid flags; table memory is not swept.
`include "assert_macros.svh"

module gap_pad_map_engine #(
	parameter int TABLE_DEPTH = gpm_pkg::TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // char_in[7:0], coord[39:8]
	input  logic [1:0]  s_tuser,   // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // char_out[7:0], answer[39:8]
	output logic [1:0]  m_tuser,   // char_kept[0], table_full[1]
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);
	import gpm_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	logic          res_valid;
	logic          res_ready;
	res_t          res;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic [AW-1:0] mem_raddr;
	entry_t        mem_rdata;

	logic          m_tvalid_q;
	res_t          out_q;

	gpm_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_func   (func_t'(s_tuser)),
		.in_char   (s_tdata[7:0]),
		.in_coord  (s_tdata[39:8]),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	gpm_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output word register
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_q.answer, out_q.char_out};
	assign m_tuser  = {out_q.table_full, out_q.char_kept};

	// a pending result holds until the output register takes it
	`ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "result changed while stalled")
	// no new word is taken while a result is pending inside
	`ASSERT_ALWAYS(a_accept_idle, !(s_tvalid && s_tready && res_valid), "input accepted with result pending")
	// a kept character never reports a full table or an answer
	`ASSERT_ALWAYS(a_kept_clean, !(m_tvalid && m_tuser[0]) || (!m_tuser[1] && m_tdata[39:8] == 32'd0), "kept character with other fields set")

endmodule
